// ===== design/bhp_pkg.sv =====
// Shared types, constants and field layout for the bitmap header field parser.
package bhp_pkg;

    localparam int ByteW  = 8;
    localparam int FieldW = 32;
    localparam int IdW    = 5;
    localparam int VerW   = 2;
    localparam int StatW  = 3;
    localparam int PosW   = 8;

    localparam logic [ByteW-1:0] SIG_B = 8'h42;
    localparam logic [ByteW-1:0] SIG_M = 8'h4D;

    localparam logic [FieldW-1:0] HSIZE_CORE = 32'd12;
    localparam logic [FieldW-1:0] HSIZE_V3   = 32'd40;
    localparam logic [FieldW-1:0] HSIZE_V4   = 32'd108;
    localparam logic [FieldW-1:0] HSIZE_V5   = 32'd124;

    localparam int InfoStart = 14;

    // position of the last header byte for each layout
    localparam logic [PosW-1:0] LAST_POS_CORE = PosW'(InfoStart + 12 - 1);
    localparam logic [PosW-1:0] LAST_POS_V3   = PosW'(InfoStart + 40 - 1);
    localparam logic [PosW-1:0] LAST_POS_V4   = PosW'(InfoStart + 108 - 1);
    localparam logic [PosW-1:0] LAST_POS_V5   = PosW'(InfoStart + 124 - 1);

    localparam logic [VerW-1:0] VER_CORE = 2'd0;
    localparam logic [VerW-1:0] VER_V3   = 2'd1;
    localparam logic [VerW-1:0] VER_V4   = 2'd2;
    localparam logic [VerW-1:0] VER_V5   = 2'd3;

    localparam logic [StatW-1:0] STAT_OK          = 3'd0;
    localparam logic [StatW-1:0] STAT_BAD_SIG     = 3'd1;
    localparam logic [StatW-1:0] STAT_RSVD_NZ     = 3'd2;
    localparam logic [StatW-1:0] STAT_BAD_HSIZE   = 3'd3;
    localparam logic [StatW-1:0] STAT_ZERO_PLANES = 3'd4;
    localparam logic [StatW-1:0] STAT_TRUNCATED   = 3'd5;

    localparam logic [IdW-1:0] FID_FILE_SIZE  = 5'd0;
    localparam logic [IdW-1:0] FID_PIX_OFFSET = 5'd1;
    localparam logic [IdW-1:0] FID_WIDTH      = 5'd2;
    localparam logic [IdW-1:0] FID_PLANES     = 5'd4;
    localparam logic [IdW-1:0] FID_COMPRESS   = 5'd6;
    localparam logic [IdW-1:0] FID_GAMMA_R    = 5'd17;

    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             end_of_stream;
    } t_in_word;

    typedef struct packed {
        logic [IdW-1:0]    field_id;
        logic [FieldW-1:0] field_value;
        logic [VerW-1:0]   header_version;
        logic [StatW-1:0]  status_code;
        logic              header_done;
    } t_out_word;

endpackage

// ===== design/bhp_ifs.sv =====
// Valid/ready channel interfaces for input bytes and parsed fields.
interface bhp_byte_if;
    import bhp_pkg::*;
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] data_byte;
    logic             end_of_stream;
    modport source(output valid, output data_byte, output end_of_stream, input ready);
    modport sink(input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface bhp_field_if;
    import bhp_pkg::*;
    logic              valid;
    logic              ready;
    logic [IdW-1:0]    field_id;
    logic [FieldW-1:0] field_value;
    logic [VerW-1:0]   header_version;
    logic [StatW-1:0]  status_code;
    logic              header_done;
    modport source(output valid, output field_id, output field_value,
                   output header_version, output status_code, output header_done,
                   input ready);
    modport sink(input valid, input field_id, input field_value,
                 input header_version, input status_code, input header_done,
                 output ready);
endinterface

// ===== design/bhp_in_stage.sv =====
// Input register: holds one byte word until the parse step consumes it.
module bhp_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bhp_byte_if.sink          i_byte,
    input  logic              i_advance,
    output logic              o_valid,
    output bhp_pkg::t_in_word o_word
);
    import bhp_pkg::*;

    logic     r_valid;
    t_in_word r_word;

    assign i_byte.ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_word.data_byte     <= i_byte.data_byte;
            r_word.end_of_stream <= i_byte.end_of_stream;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ===== design/bhp_step.sv =====
// Per-byte parse step: position tracking, field gathering and error checks.
module bhp_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  bhp_pkg::t_in_word  i_word,
    output logic               o_load,
    output bhp_pkg::t_out_word o_word
);
    import bhp_pkg::*;

    typedef struct packed {
        logic           hit;
        logic [1:0]     k;
        logic           last;
        logic [IdW-1:0] id;
    } t_span;

    logic [PosW-1:0]   r_pos;
    logic [FieldW-1:0] r_acc;
    logic [VerW-1:0]   r_ver;
    logic              r_ignore;

    logic [FieldW-1:0] n_acc;
    logic [VerW-1:0]   n_ver;
    logic [StatW-1:0]  status;
    logic [FieldW-1:0] value;
    logic [IdW-1:0]    id;
    logic              emit;
    logic              done;
    t_span             span;

    function automatic logic [FieldW-1:0] gather(logic [FieldW-1:0] acc, logic [1:0] k,
                                                 logic [ByteW-1:0] b);
        logic [FieldW-1:0] res;
        res = acc;
        case (k)
            2'd0:    res = {24'd0, b};
            2'd1:    res[15:8]  = acc[15:8]  | b;
            2'd2:    res[23:16] = acc[23:16] | b;
            default: res[31:24] = acc[31:24] | b;
        endcase
        return res;
    endfunction

    // layout fields from byte 18 on; gaps (endpoints) give no hit
    function automatic t_span layout_span(logic is_core, logic [PosW-1:0] p);
        t_span            s;
        logic [PosW-1:0]  d;
        s = '0;
        d = '0;
        if (is_core) begin
            if (p >= 8'd18 && p <= 8'd25) begin
                d      = p - 8'd18;
                s.hit  = 1'b1;
                s.k    = {1'b0, d[0]};
                s.last = d[0];
                s.id   = FID_WIDTH + {3'd0, d[2:1]};
            end
        end else if (p >= 8'd18 && p <= 8'd25) begin
            d      = p - 8'd18;
            s.hit  = 1'b1;
            s.k    = d[1:0];
            s.last = &d[1:0];
            s.id   = FID_WIDTH + {4'd0, d[2]};
        end else if (p >= 8'd26 && p <= 8'd29) begin
            d      = p - 8'd26;
            s.hit  = 1'b1;
            s.k    = {1'b0, d[0]};
            s.last = d[0];
            s.id   = FID_PLANES + {4'd0, d[1]};
        end else if (p >= 8'd30 && p <= 8'd73) begin
            d      = p - 8'd30;
            s.hit  = 1'b1;
            s.k    = d[1:0];
            s.last = &d[1:0];
            s.id   = FID_COMPRESS + {1'b0, d[5:2]};
        end else if (p >= 8'd110 && p <= 8'd137) begin
            d      = p - 8'd110;
            s.hit  = 1'b1;
            s.k    = d[1:0];
            s.last = &d[1:0];
            s.id   = FID_GAMMA_R + {2'd0, d[4:2]};
        end
        return s;
    endfunction

    function automatic logic [PosW-1:0] last_pos(logic [VerW-1:0] v);
        logic [PosW-1:0] lp;
        unique case (v)
            VER_CORE: lp = LAST_POS_CORE;
            VER_V3:   lp = LAST_POS_V3;
            VER_V4:   lp = LAST_POS_V4;
            default:  lp = LAST_POS_V5;
        endcase
        return lp;
    endfunction

    always_comb begin
        logic [ByteW-1:0] b;
        logic [ByteW-1:0] want;
        b      = i_word.data_byte;
        want   = (r_acc[ByteW-1:0] == SIG_B) ? SIG_M : SIG_B;
        n_acc  = r_acc;
        n_ver  = r_ver;
        status = STAT_OK;
        value  = '0;
        id     = FID_FILE_SIZE;
        emit   = 1'b0;
        done   = 1'b0;
        span   = layout_span(r_ver == VER_CORE, r_pos);

        if (r_pos == 8'd0) begin
            if (b != SIG_B && b != SIG_M) begin
                status = STAT_BAD_SIG;
                value  = {24'd0, b};
            end else begin
                n_acc = {24'd0, b};
            end
        end else if (r_pos == 8'd1) begin
            if (b != want) begin
                status = STAT_BAD_SIG;
                value  = {24'd0, b};
            end else begin
                n_acc = '0;
            end
        end else if (r_pos <= 8'd5) begin
            n_acc = gather(r_acc, r_pos[1:0] - 2'd2, b);
            if (r_pos == 8'd5) begin
                emit  = 1'b1;
                id    = FID_FILE_SIZE;
                value = n_acc;
            end
        end else if (r_pos <= 8'd9) begin
            if (b != '0) begin
                status = STAT_RSVD_NZ;
                value  = {24'd0, b};
            end
        end else if (r_pos <= 8'd13) begin
            n_acc = gather(r_acc, r_pos[1:0] - 2'd2, b);
            if (r_pos == 8'd13) begin
                emit  = 1'b1;
                id    = FID_PIX_OFFSET;
                value = n_acc;
            end
        end else if (r_pos <= 8'd17) begin
            n_acc = gather(r_acc, r_pos[1:0] - 2'd2, b);
            if (r_pos == 8'd17) begin
                if (n_acc == HSIZE_CORE) begin
                    n_ver = VER_CORE;
                end else if (n_acc == HSIZE_V3) begin
                    n_ver = VER_V3;
                end else if (n_acc == HSIZE_V4) begin
                    n_ver = VER_V4;
                end else if (n_acc == HSIZE_V5) begin
                    n_ver = VER_V5;
                end else begin
                    status = STAT_BAD_HSIZE;
                    value  = n_acc;
                end
            end
        end else if (span.hit) begin
            n_acc = gather(r_acc, span.k, b);
            if (span.last) begin
                if (span.id == FID_PLANES && n_acc == '0) begin
                    status = STAT_ZERO_PLANES;
                    value  = '0;
                end else begin
                    emit  = 1'b1;
                    id    = span.id;
                    value = n_acc;
                    done  = (r_pos == last_pos(r_ver));
                end
            end
        end

        if (status != STAT_OK) begin
            emit = 1'b1;
            done = 1'b1;
            id   = FID_FILE_SIZE;
        end else if (i_word.end_of_stream && !done) begin
            emit   = 1'b1;
            done   = 1'b1;
            status = STAT_TRUNCATED;
            id     = FID_FILE_SIZE;
            value  = '0;
        end

        // bytes after the header, or after an error, are dropped
        if (r_ignore) begin
            emit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_acc    <= '0;
            r_ver    <= VER_CORE;
            r_ignore <= 1'b0;
        end else if (i_fire) begin
            if (i_word.end_of_stream) begin
                r_pos    <= '0;
                r_acc    <= '0;
                r_ver    <= VER_CORE;
                r_ignore <= 1'b0;
            end else if (!r_ignore) begin
                r_acc <= n_acc;
                r_ver <= n_ver;
                if (done) begin
                    r_ignore <= 1'b1;
                end else begin
                    r_pos <= r_pos + 8'd1;
                end
            end
        end
    end

    assign o_load                = i_fire && emit;
    assign o_word.field_id       = id;
    assign o_word.field_value    = value;
    assign o_word.header_version = n_ver;
    assign o_word.status_code    = status;
    assign o_word.header_done    = done;

endmodule

// ===== design/bhp_out_stage.sv =====
// Result register: holds one field word until the sink takes it.
module bhp_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  bhp_pkg::t_out_word i_word,
    output logic               o_space,
    bhp_field_if.source        o_field
);
    import bhp_pkg::*;

    logic      r_valid;
    t_out_word r_word;

    assign o_space = !r_valid || o_field.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_field.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

    assign o_field.valid          = r_valid;
    assign o_field.field_id       = r_word.field_id;
    assign o_field.field_value    = r_word.field_value;
    assign o_field.header_version = r_word.header_version;
    assign o_field.status_code    = r_word.status_code;
    assign o_field.header_done    = r_word.header_done;

endmodule

// ===== design/bmp_header_field_parser.sv =====
// Bitmap header field parser: byte in, one field word per completed field or error.
// A field word is loaded into the result register as its last byte is parsed.
// Throughput: one byte per cycle; the input register, the parse step and the
// result register form a two-stage pipe that advances whenever the result slot is free.
// Reset (i_rst_n low, synchronous): pipe emptied, parser waits for the first byte
// of a new file.
module bmp_header_field_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bhp_byte_if.sink    i_byte,
    bhp_field_if.source o_field
);
    import bhp_pkg::*;

    logic      in_valid;
    t_in_word  in_word;
    logic      out_space;
    logic      fire;
    logic      load;
    t_out_word step_word;

    assign fire = in_valid && out_space;

    bhp_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (i_byte),
        .i_advance (fire),
        .o_valid   (in_valid),
        .o_word    (in_word)
    );

    bhp_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_word  (in_word),
        .o_load  (load),
        .o_word  (step_word)
    );

    bhp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_word  (step_word),
        .o_space (out_space),
        .o_field (o_field)
    );

endmodule

// ===== tb/bhp_field_checker.sv =====
// Field word checker: predicts parser output from accepted bytes and compares results.
`timescale 1ns / 1ps
module bhp_field_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    bhp_byte_if  i_byte_ch,
    bhp_field_if i_field_ch,
    output int   o_fail_count,
    output int   o_pending
);
    import bhp_pkg::*;

    typedef enum logic {PH_PARSE, PH_SKIP} t_phase;

    logic [PosW-1:0]   pos;
    logic [FieldW-1:0] acc;
    logic [VerW-1:0]   ver;
    t_phase            phase;
    t_out_word         field_q[$];

    task automatic clear_file();
        pos   = '0;
        acc   = '0;
        ver   = VER_CORE;
        phase = PH_PARSE;
    endtask

    task automatic shift_in(input logic [1:0] k, input logic [ByteW-1:0] b);
        if (k == 2'd0) acc = FieldW'(b);
        else acc |= FieldW'(b) << (8 * k);
    endtask

    // Locate the layout field that holds byte p; last is set on its final byte.
    function automatic logic find_span(input logic [VerW-1:0] v, input logic [PosW-1:0] p,
                                       output logic [IdW-1:0] fid, output logic [1:0] k,
                                       output logic last);
        int off;
        int len;
        fid  = '0;
        k    = '0;
        last = 1'b0;
        len  = 4;
        if (p < 18) return 1'b0;
        off = int'(p) - 18;
        if (v == VER_CORE) begin
            if (p > 25) return 1'b0;
            len = 2;
            fid = FID_WIDTH + IdW'(off / 2);
        end else if (p <= 25) begin
            fid = FID_WIDTH + IdW'(off / 4);
        end else if (p <= 29) begin
            off = int'(p) - 26;
            len = 2;
            fid = FID_PLANES + IdW'(off / 2);
        end else if (p <= 73) begin
            off = int'(p) - 30;
            fid = FID_COMPRESS + IdW'(off / 4);
        end else if (p >= 110 && p <= 137) begin
            // endpoint bytes 74..109 are skipped
            off = int'(p) - 110;
            fid = FID_GAMMA_R + IdW'(off / 4);
        end else begin
            return 1'b0;
        end
        k    = 2'(off % len);
        last = (int'(k) == len - 1);
        return 1'b1;
    endfunction

    function automatic logic [PosW-1:0] header_last_pos(input logic [VerW-1:0] v);
        case (v)
            VER_CORE: return LAST_POS_CORE;
            VER_V3:   return LAST_POS_V3;
            VER_V4:   return LAST_POS_V4;
            default:  return LAST_POS_V5;
        endcase
    endfunction

    task automatic parse_byte(input logic [ByteW-1:0] b, input logic eos);
        t_out_word     w;
        logic          emit;
        logic          done;
        logic          hit;
        logic          last;
        logic [IdW-1:0] fid;
        logic [1:0]    k;
        w    = '0;
        emit = 1'b0;
        done = 1'b0;
        if (phase == PH_SKIP) begin
            if (eos) clear_file();
            return;
        end
        if (pos == 0) begin
            if (b != SIG_B && b != SIG_M) begin
                w.status_code = STAT_BAD_SIG;
                w.field_value = FieldW'(b);
            end else begin
                acc = FieldW'(b);
            end
        end else if (pos == 1) begin
            if (b != ((acc == FieldW'(SIG_B)) ? SIG_M : SIG_B)) begin
                w.status_code = STAT_BAD_SIG;
                w.field_value = FieldW'(b);
            end else begin
                acc = '0;
            end
        end else if (pos <= 5) begin
            shift_in(2'(pos - 2), b);
            if (pos == 5) begin
                emit          = 1'b1;
                w.field_id    = FID_FILE_SIZE;
                w.field_value = acc;
            end
        end else if (pos <= 9) begin
            if (b != '0) begin
                w.status_code = STAT_RSVD_NZ;
                w.field_value = FieldW'(b);
            end
        end else if (pos <= 13) begin
            shift_in(2'(pos - 10), b);
            if (pos == 13) begin
                emit          = 1'b1;
                w.field_id    = FID_PIX_OFFSET;
                w.field_value = acc;
            end
        end else if (pos <= 17) begin
            shift_in(2'(pos - 14), b);
            if (pos == 17) begin
                case (acc)
                    HSIZE_CORE: ver = VER_CORE;
                    HSIZE_V3:   ver = VER_V3;
                    HSIZE_V4:   ver = VER_V4;
                    HSIZE_V5:   ver = VER_V5;
                    default: begin
                        w.status_code = STAT_BAD_HSIZE;
                        w.field_value = acc;
                    end
                endcase
            end
        end else begin
            hit = find_span(ver, pos, fid, k, last);
            if (hit) begin
                shift_in(k, b);
                if (last) begin
                    if (fid == FID_PLANES && acc == '0) begin
                        w.status_code = STAT_ZERO_PLANES;
                        w.field_value = '0;
                    end else begin
                        emit          = 1'b1;
                        w.field_id    = fid;
                        w.field_value = acc;
                        done          = (pos == header_last_pos(ver));
                    end
                end
            end
        end

        // errors report under field id 0
        if (w.status_code != STAT_OK) begin
            emit       = 1'b1;
            done       = 1'b1;
            w.field_id = FID_FILE_SIZE;
        end else if (eos && !done) begin
            emit          = 1'b1;
            done          = 1'b1;
            w.status_code = STAT_TRUNCATED;
            w.field_id    = FID_FILE_SIZE;
            w.field_value = '0;
        end
        w.header_version = ver;
        w.header_done    = done;
        if (emit) field_q.push_back(w);

        if (eos) clear_file();
        else if (done) phase = PH_SKIP;
        else pos = pos + 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_out_word got;
        t_out_word exp_w;
        if (!i_rst_n) begin
            clear_file();
            field_q.delete();
            o_fail_count = 0;
        end else begin
            // a result never comes from the byte taken at the same edge
            if (i_field_ch.valid && i_field_ch.ready) begin
                got.field_id       = i_field_ch.field_id;
                got.field_value    = i_field_ch.field_value;
                got.header_version = i_field_ch.header_version;
                got.status_code    = i_field_ch.status_code;
                got.header_done    = i_field_ch.header_done;
                if (field_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("checker: unexpected word id=%0d val=%h ver=%0d st=%0d done=%0b",
                                 got.field_id, got.field_value, got.header_version,
                                 got.status_code, got.header_done);
                end else begin
                    exp_w = field_q.pop_front();
                    if (got !== exp_w) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"checker: mismatch exp id=%0d val=%h ver=%0d st=%0d ",
                                      "done=%0b got id=%0d val=%h ver=%0d st=%0d done=%0b"},
                                     exp_w.field_id, exp_w.field_value, exp_w.header_version,
                                     exp_w.status_code, exp_w.header_done,
                                     got.field_id, got.field_value, got.header_version,
                                     got.status_code, got.header_done);
                    end
                end
            end
            if (i_byte_ch.valid && i_byte_ch.ready)
                parse_byte(i_byte_ch.data_byte, i_byte_ch.end_of_stream);
        end
        o_pending = field_q.size();
    end

endmodule

// ===== tb/tb_bmp_header_field_parser.sv =====
// Testbench top: bitmap byte streams in, field words checked by the checker beside the parser.
`timescale 1ns / 1ps
module tb_bmp_header_field_parser;
    import bhp_pkg::*;

    localparam int ItemTarget = 1450;
    localparam int CycleLimit = 300000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycles = 0;
    int   items  = 0;
    int   send_idle_pct;
    int   recv_idle_pct;
    logic [ByteW-1:0] file_bytes[$];

    bhp_byte_if  byte_ch ();
    bhp_field_if field_ch ();

    bmp_header_field_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_field (field_ch)
    );

    bhp_field_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_ch    (byte_ch),
        .i_field_ch   (field_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        field_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_byte(input logic [ByteW-1:0] b, input logic eos);
        while ($urandom_range(99) < send_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        byte_ch.valid         <= 1'b1;
        byte_ch.data_byte     <= b;
        byte_ch.end_of_stream <= eos;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic push_le(input logic [31:0] v);
        for (int i = 0; i < 4; i++) file_bytes.push_back(v[8*i +: 8]);
    endtask

    // Builds one file image; most are well-formed, the rest truncated, broken or noise.
    task automatic make_file(output logic noisy);
        int   kind;
        int   pick;
        int   hsize;
        int   pp;
        int   epos;
        logic [31:0] bad_size;
        file_bytes.delete();
        noisy = 1'b0;
        kind  = $urandom_range(99);
        if (kind >= 92) begin
            noisy = 1'b1;
            repeat ($urandom_range(1, 20)) file_bytes.push_back(ByteW'($urandom_range(255)));
            return;
        end
        pick  = $urandom_range(99);
        hsize = (pick < 35) ? int'(HSIZE_CORE) : (pick < 60) ? int'(HSIZE_V3) :
                (pick < 80) ? int'(HSIZE_V4) : int'(HSIZE_V5);
        if ($urandom_range(1)) begin
            file_bytes.push_back(SIG_B);
            file_bytes.push_back(SIG_M);
        end else begin
            file_bytes.push_back(SIG_M);
            file_bytes.push_back(SIG_B);
        end
        push_le($urandom);
        push_le('0);
        push_le($urandom);
        push_le(32'(hsize));
        while (file_bytes.size() < InfoStart + hsize)
            file_bytes.push_back(ByteW'($urandom_range(255)));
        pp = (hsize == int'(HSIZE_CORE)) ? 22 : 26;
        if (file_bytes[pp] == '0 && file_bytes[pp+1] == '0) file_bytes[pp] = 8'd1;
        epos   = -1;

        if (kind < 55) begin
            repeat ($urandom_range(0, 4)) file_bytes.push_back(ByteW'($urandom_range(255)));
            return;
        end else if (kind < 67) begin
            // end of stream inside the header
            epos = $urandom_range(0, file_bytes.size() - 2);
            while (file_bytes.size() > epos + 1) void'(file_bytes.pop_back());
            return;
        end else if (kind < 72) begin
            epos = $urandom_range(1);
            do file_bytes[epos] = ByteW'($urandom_range(255));
            while ((epos == 0) ? (file_bytes[0] == SIG_B || file_bytes[0] == SIG_M) :
                   (file_bytes[1] == ((file_bytes[0] == SIG_B) ? SIG_M : SIG_B)));
        end else if (kind < 77) begin
            epos = $urandom_range(6, 9);
            file_bytes[epos] = ByteW'($urandom_range(1, 255));
        end else if (kind < 85) begin
            epos = 17;
            case ($urandom_range(3))
                0: bad_size = $urandom;
                1: bad_size = 32'(hsize + 1);
                2: bad_size = 32'(hsize - 1);
                default: bad_size = '0;
            endcase
            if (bad_size inside {HSIZE_CORE, HSIZE_V3, HSIZE_V4, HSIZE_V5})
                bad_size ^= 32'h100;
            for (int i = 0; i < 4; i++) file_bytes[14+i] = bad_size[8*i +: 8];
        end else begin
            epos = pp + 1;
            file_bytes[pp]   = '0;
            file_bytes[pp+1] = '0;
        end
        // sometimes the error byte also ends the stream
        if ($urandom_range(2) == 0)
            while (file_bytes.size() > epos + 1) void'(file_bytes.pop_back());
    endtask

    initial begin
        logic noisy;
        int   n;
        i_rst_n               = 1'b0;
        byte_ch.valid         = 1'b0;
        byte_ch.data_byte     = '0;
        byte_ch.end_of_stream = 1'b0;
        field_ch.ready        = 1'b0;
        send_idle_pct         = 7;
        recv_idle_pct         = 86;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // bad first byte together with end of stream
        send_byte(8'hFF, 1'b1);
        // second signature byte repeats the first; rest ignored
        send_byte(SIG_B, 1'b0);
        send_byte(SIG_B, 1'b0);
        send_byte(8'h00, 1'b1);
        // stream ends after one good byte
        send_byte(SIG_M, 1'b1);
        // max file size, then reserved nonzero
        send_byte(SIG_M, 1'b0);
        send_byte(SIG_B, 1'b0);
        repeat (4) send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b1);
        // end of stream on the byte that completes file size
        send_byte(SIG_B, 1'b0);
        send_byte(SIG_M, 1'b0);
        repeat (3) send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        items += 20;

        for (int st = 0; st < 3; st++) begin
            send_idle_pct = (st == 0) ? 7 : (st == 1) ? 86 : 0;
            recv_idle_pct = (st == 0) ? 86 : (st == 1) ? 7 : 0;
            while (items < ItemTarget * (st + 1) / 3) begin
                make_file(noisy);
                n = file_bytes.size();
                for (int i = 0; i < n; i++)
                    send_byte(file_bytes[i],
                              (i == n - 1) || (noisy && $urandom_range(5) == 0));
                items += n;
            end
            // hold the sender off until every pending word has drained
            byte_ch.valid <= 1'b0;
            @(negedge i_clk);
            while (pending != 0) @(negedge i_clk);
        end

        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/bhp_pkg.sv
design/bhp_ifs.sv
design/bhp_in_stage.sv
design/bhp_step.sv
design/bhp_out_stage.sv
design/bmp_header_field_parser.sv
tb/bhp_field_checker.sv
tb/tb_bmp_header_field_parser.sv
